/* rtl/core/hmps_pkg.sv */
package hmps_pkg;

  // Register widths
  localparam int unsigned WakeLimitW  = 8;
  localparam int unsigned VoltW       = 10;
  localparam int unsigned WarmupW     = 10;
  localparam int unsigned BlankW      = 14;
  localparam int unsigned TimeoutW    = 14;
  localparam int unsigned MeasW       = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 3;

  // Wake counter saturates at 256 so a limit of 255 can still be exceeded
  localparam int unsigned WakeCntW    = 9;
  localparam logic [WakeCntW-1:0] WakeCntMax = 9'd256;

  // Signed tick counter: spans -(blanking-1) up to the longest measure time
  localparam int unsigned TickW       = 17;

  // Stream payload widths
  localparam int unsigned InDataW     = 16;
  localparam int unsigned InUserW     = 1;
  localparam int unsigned OutDataW    = 8;

  // Register reset values
  localparam logic [WakeLimitW-1:0] WakeLimitRst = 8'd37;
  localparam logic [VoltW-1:0]      VoltThrRst   = 10'd512;
  localparam logic [WarmupW-1:0]    WarmupRst    = 10'd5;
  localparam logic [BlankW-1:0]     BlankRst     = 14'd500;
  localparam logic [TimeoutW-1:0]   TimeoutRst   = 14'd3500;
  localparam logic [MeasW-1:0]      MeasRst      = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAKE_LIMIT = 3'd0,
    CFG_VOLT_THR   = 3'd1,
    CFG_WARMUP     = 3'd2,
    CFG_BLANKING   = 3'd3,
    CFG_TIMEOUT    = 3'd4,
    CFG_MEASURE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SLEEP = 2'd0,
    PH_WARM  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_MEAS  = 2'd3
  } phase_e;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  // One result beat
  typedef struct packed {
    logic       low_voltage_skip;
    logic       timed_out;
    phase_e     phase;
    logic       measure_line;
    logic       second_power;
    logic       first_power;
  } result_t;

endpackage

/* rtl/core/harvest_measure_power_sequencer.sv */
// Channel   Dir  Beat contents (low bit first)
// --------  ---  ----------------------------------------------------------
// s_axis    in   tdata: cap_voltage[9:0], ready_level[10], zero fill
//                tuser: kind (0 = 10 ms tick, 1 = watchdog wake)
// m_axis    out  tdata: first_power, second_power, measure_line,
//                phase[4:3], timed_out, low_voltage_skip, zero fill
// cfg       in   cfg_we_i / cfg_index_i / cfg_data_i, write only
//
// Each input beat is handled in the cycle it is accepted: the sequencer
// state updates at that edge and the result lands in the output register,
// or in the skid entry if that register still holds a beat. With the buffer
// empty, m_axis_tvalid rises in the cycle after acceptance. The two-entry
// buffer sustains one beat per cycle; s_axis_tready drops only when full.
// Reset is asynchronous, active low; it loads register defaults, clears the
// counters and arms the first-item count check.
module harvest_measure_power_sequencer
  import hmps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // cap_voltage, ready_level
  input  logic [InUserW-1:0]  s_axis_tuser,   // kind

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // first_power, second_power,
                                              // measure_line, phase,
                                              // timed_out, low_voltage_skip

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [WakeLimitW-1:0] wake_limit_q;
  logic [VoltW-1:0]      volt_thr_q;
  logic [WarmupW-1:0]    warmup_q;
  logic [BlankW-1:0]     blank_q;
  logic [TimeoutW-1:0]   timeout_q;
  logic [MeasW-1:0]      meas_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_limit_q <= WakeLimitRst;
      volt_thr_q   <= VoltThrRst;
      warmup_q     <= WarmupRst;
      blank_q      <= BlankRst;
      timeout_q    <= TimeoutRst;
      meas_q       <= MeasRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WAKE_LIMIT: wake_limit_q <= cfg_data_i[WakeLimitW-1:0];
        CFG_VOLT_THR:   volt_thr_q   <= cfg_data_i[VoltW-1:0];
        CFG_WARMUP:     warmup_q     <= cfg_data_i[WarmupW-1:0];
        CFG_BLANKING:   blank_q      <= cfg_data_i[BlankW-1:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i[TimeoutW-1:0];
        CFG_MEASURE:    meas_q       <= cfg_data_i[MeasW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input beat fields
  // ---------------------------------------------------------------------
  logic             in_kind;
  logic [VoltW-1:0] in_vcap;
  logic             in_ready_n;
  logic             in_fire;

  assign in_kind    = s_axis_tuser[0];
  assign in_vcap    = s_axis_tdata[VoltW-1:0];
  assign in_ready_n = s_axis_tdata[VoltW];
  assign in_fire    = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  phase_e                   phase_q, phase_d;
  logic [WakeCntW-1:0]      wake_cnt_q, wake_cnt_d;
  logic signed [TickW-1:0]  tick_q, tick_d;
  logic                     first_q;
  logic                     tmo_d, skip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SLEEP;
      wake_cnt_q <= '0;
      tick_q     <= '0;
      first_q    <= 1'b1;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      wake_cnt_q <= wake_cnt_d;
      tick_q     <= tick_d;
      first_q    <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    logic [WakeCntW-1:0]     cnt0;
    logic                    trig;
    logic signed [TickW-1:0] tick_inc;
    logic signed [TickW-1:0] wait_start;
    logic signed [TickW-1:0] tmo_lim;

    // The pre-sleep check on the first item always sees a zero count and
    // only bumps it to one.
    cnt0       = first_q ? WakeCntW'(1) : wake_cnt_q;
    trig       = cnt0 > {1'b0, wake_limit_q};
    tick_inc   = tick_q + TickW'(1);
    wait_start = TickW'(1) - $signed({{(TickW-BlankW){1'b0}}, blank_q});
    tmo_lim    = $signed({{(TickW-TimeoutW){1'b0}}, timeout_q});

    phase_d    = phase_q;
    wake_cnt_d = cnt0;
    tick_d     = tick_q;
    tmo_d      = 1'b0;
    skip_d     = 1'b0;

    if (in_kind == KIND_WAKE) begin
      if (phase_q == PH_SLEEP) begin
        if (trig) begin
          wake_cnt_d = '0;
          if (in_vcap > volt_thr_q) begin
            if (warmup_q == '0) begin
              phase_d = PH_WAIT;
              tick_d  = wait_start;
            end else begin
              phase_d = PH_WARM;
              tick_d  = '0;
            end
          end else begin
            skip_d = 1'b1;
          end
        end else if (cnt0 < WakeCntMax) begin
          wake_cnt_d = cnt0 + WakeCntW'(1);
        end
      end
    end else begin
      case (phase_q)
        PH_WARM: begin
          if ($unsigned(tick_inc) >= {{(TickW-WarmupW){1'b0}}, warmup_q}) begin
            phase_d = PH_WAIT;
            tick_d  = wait_start;
          end else begin
            tick_d  = tick_inc;
          end
        end
        PH_WAIT: begin
          if (!in_ready_n && (tick_q > 0)) begin
            tick_d  = '0;
            phase_d = (meas_q == '0) ? PH_SLEEP : PH_MEAS;
          end else if (tick_q <= tmo_lim) begin
            tick_d  = tick_inc;
          end else begin
            tmo_d   = 1'b1;
            phase_d = PH_SLEEP;
            tick_d  = '0;
          end
        end
        PH_MEAS: begin
          if ($unsigned(tick_inc) >= {{(TickW-MeasW){1'b0}}, meas_q}) begin
            phase_d = PH_SLEEP;
            tick_d  = '0;
          end else begin
            tick_d  = tick_inc;
          end
        end
        default: ;  // ticks while sleeping do nothing
      endcase
    end
  end

  // Outputs: power lines decode from the phase after the beat
  result_t res_d;

  always_comb begin
    res_d.first_power      = (phase_d != PH_SLEEP);
    res_d.second_power     = (phase_d == PH_WAIT) || (phase_d == PH_MEAS);
    res_d.measure_line     = (phase_d == PH_MEAS);
    res_d.phase            = phase_d;
    res_d.timed_out        = tmo_d;
    res_d.low_voltage_skip = skip_d;
  end

  // ---------------------------------------------------------------------
  // Output register plus skid entry
  // ---------------------------------------------------------------------
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    out_pop;

  assign out_pop       = out_vld_q & m_axis_tready;
  assign s_axis_tready = ~skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_pop) begin
        out_vld_q  <= skid_vld_q | in_fire;
        skid_vld_q <= 1'b0;
      end else if (in_fire) begin
        if (out_vld_q) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop && skid_vld_q) begin
      out_q <= skid_q;
    end else if (in_fire && (!out_vld_q || out_pop)) begin
      out_q <= res_d;
    end
    if (in_fire && out_vld_q && !out_pop) begin
      skid_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  // The skid entry only fills behind a held output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without output entry");

  // A beat taken while the buffer was empty shows up on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_vld_q) |=> (m_axis_tvalid && (out_q == $past(res_d))))
    else $error("accepted beat did not reach the output register");

  // Timeout and low-voltage skip come from exclusive paths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_q.timed_out && out_q.low_voltage_skip))
    else $error("timeout and skip flagged on the same beat");

  // A timeout always leaves everything powered down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.timed_out) |-> !out_q.first_power)
    else $error("timeout beat with power still on");
`endif

endmodule

/* tb/sv/harvest_measure_power_sequencer_tb.sv */
`timescale 1ns / 100ps

module harvest_measure_power_sequencer_tb
  import hmps_pkg::*;
();

  // Watchdog: a correct run is about 1400 beats
  localparam int unsigned CycleLimit = 200_000;
  localparam int          MaxPrinted = 40;

  // Expected power state per accepted event, kept in step with the sequencer
  class sequencer_scoreboard;
    // register copies
    int limit_wakes, volt_thr, warm_len, blank_len, tmo_len, meas_len;
    // sequencer state
    int     wake_cnt;
    phase_e phase;
    int     tick_cnt;
    bit     first_pending;
    bit     fired;          // last event was a wake whose count check fired
    result_t expected_states[$];
    int     errors;
    int     n_checked;

    function new();
      limit_wakes   = int'(WakeLimitRst);
      volt_thr      = int'(VoltThrRst);
      warm_len      = int'(WarmupRst);
      blank_len     = int'(BlankRst);
      tmo_len       = int'(TimeoutRst);
      meas_len      = int'(MeasRst);
      wake_cnt      = 0;
      phase         = PH_SLEEP;
      tick_cnt      = 0;
      first_pending = 1'b1;
      fired         = 1'b0;
      errors        = 0;
      n_checked     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, int val);
      case (idx)
        CFG_WAKE_LIMIT: limit_wakes = val & 'hFF;
        CFG_VOLT_THR:   volt_thr    = val & 'h3FF;
        CFG_WARMUP:     warm_len    = val & 'h3FF;
        CFG_BLANKING:   blank_len   = val & 'h3FFF;
        CFG_TIMEOUT:    tmo_len     = val & 'h3FFF;
        CFG_MEASURE:    meas_len    = val & 'hFFFF;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    // Count saturates at 256 so that a limit of 255 is still exceeded
    function bit wake_count_check();
      if (wake_cnt > limit_wakes) begin
        wake_cnt = 0;
        return 1'b1;
      end
      if (wake_cnt < 256) wake_cnt++;
      return 1'b0;
    endfunction

    function void enter_wait();
      phase    = PH_WAIT;
      tick_cnt = 1 - blank_len;
    endfunction

    function void apply_event(logic kind, logic [VoltW-1:0] vcap, logic rdy);
      result_t want;
      logic    tmo, skip;
      tmo   = 1'b0;
      skip  = 1'b0;
      fired = 1'b0;
      // check made before the first sleep; can never fire
      if (first_pending) begin
        first_pending = 1'b0;
        void'(wake_count_check());
      end
      if (kind == KIND_WAKE) begin
        if (phase == PH_SLEEP && wake_count_check()) begin
          fired = 1'b1;
          if (vcap > volt_thr) begin
            tick_cnt = 0;
            if (warm_len == 0) enter_wait();
            else phase = PH_WARM;
          end else begin
            skip = 1'b1;
          end
        end
      end else begin
        case (phase)
          PH_WARM: begin
            tick_cnt++;
            if (tick_cnt >= warm_len) enter_wait();
          end
          PH_WAIT: begin
            if (!rdy && tick_cnt > 0) begin
              tick_cnt = 0;
              phase    = (meas_len == 0) ? PH_SLEEP : PH_MEAS;
            end else if (tick_cnt <= tmo_len) begin
              tick_cnt++;
            end else begin
              tmo      = 1'b1;
              phase    = PH_SLEEP;
              tick_cnt = 0;
            end
          end
          PH_MEAS: begin
            tick_cnt++;
            if (tick_cnt >= meas_len) begin
              phase    = PH_SLEEP;
              tick_cnt = 0;
            end
          end
          default: ;
        endcase
      end
      want.first_power      = (phase != PH_SLEEP);
      want.second_power     = (phase == PH_WAIT || phase == PH_MEAS);
      want.measure_line     = (phase == PH_MEAS);
      want.phase            = phase;
      want.timed_out        = tmo;
      want.low_voltage_skip = skip;
      expected_states.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (errors < MaxPrinted) $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [1:0] got_v, logic [1:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                  n_checked, name, got_v, want_v));
    endtask

    task check_state(logic [OutDataW-1:0] data);
      result_t got, want;
      if (expected_states.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", data));
        return;
      end
      want = expected_states.pop_front();
      got  = result_t'(data[$bits(result_t)-1:0]);
      n_checked++;
      cmp_field("first_power",  2'(got.first_power),  2'(want.first_power));
      cmp_field("second_power", 2'(got.second_power), 2'(want.second_power));
      cmp_field("measure_line", 2'(got.measure_line), 2'(want.measure_line));
      cmp_field("phase",        got.phase,            want.phase);
      cmp_field("timed_out",    2'(got.timed_out),    2'(want.timed_out));
      cmp_field("low_voltage_skip", 2'(got.low_voltage_skip),
                2'(want.low_voltage_skip));
      cmp_field("zero fill", 2'(data[OutDataW-1:$bits(result_t)]), 2'd0);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // cap_voltage[9:0], ready_level[10], zero fill
  logic [InUserW-1:0]  s_axis_tuser  = '0;  // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // first_power, second_power, measure_line,
                                            // phase[4:3], timed_out, low_voltage_skip
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  sequencer_scoreboard sb = new();

  // Idle rates in percent, and a hold-off on the result side counted in cycles
  int src_idle_pct = 30;
  int snk_idle_pct = 30;
  int snk_hold     = 0;
  int unsigned cycle_cnt;

  harvest_measure_power_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random back-pressure, or a solid hold-off while snk_hold runs down
  initial begin
    forever begin
      @(posedge clk_i);
      if (snk_hold > 0) begin
        snk_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Result beats are sampled at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_state(m_axis_tdata);
  end

  // Offer one event beat, with random idle cycles ahead of it, and hand it to
  // the scoreboard at the edge that accepts it. tvalid stays up on return so
  // back-to-back beats keep it high.
  task automatic push_beat(logic kind, logic [VoltW-1:0] vcap, logic rdy);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(InDataW-VoltW-1){1'b0}}, rdy, vcap};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_event(kind, vcap, rdy);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Registers only change with the block idle; all six are rewritten each time
  task automatic load_setting(int lim, int thr, int warm, int blank, int tmo, int meas);
    int vals[6];
    vals = '{lim, thr, warm, blank, tmo, meas};
    drain_results();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i][CfgDataW-1:0];
      @(posedge clk_i);
      sb.write_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: wakes while asleep, ticks while busy, with some
  // out-of-place beats mixed in. Voltage often sits right at the threshold.
  task automatic random_beat(int ready_low_pct, output bit counted);
    logic             kind, rdy;
    logic [VoltW-1:0] vcap;
    int               r;
    r    = $urandom_range(99);
    rdy  = 1'($urandom_range(1));
    vcap = $urandom_range(1) ? VoltW'($urandom_range(1023))
                             : VoltW'(sb.volt_thr + $urandom_range(2) - 1);
    if (sb.phase == PH_SLEEP) begin
      kind = (r < 85) ? KIND_WAKE : KIND_TICK;
    end else begin
      kind = (r < 8) ? KIND_WAKE : KIND_TICK;
      if (sb.phase == PH_WAIT) rdy = ($urandom_range(99) < ready_low_pct) ? 1'b0 : 1'b1;
    end
    // wakes while busy and ticks while asleep are dropped by the block
    counted = ((kind == KIND_WAKE) == (sb.phase == PH_SLEEP));
    push_beat(kind, vcap, rdy);
  endtask

  task automatic wake_until_fired(logic [VoltW-1:0] vcap);
    do push_beat(KIND_WAKE, vcap, 1'($urandom_range(1))); while (!sb.fired);
  endtask

  initial begin
    bit counted;
    int useful;
    int ready_low_pct;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // limit 1, threshold 100, warm-up 2, blanking 2, timeout 3, measure 2
    load_setting(1, 100, 2, 2, 3, 2);
    // first beat: extra count check first, so the third beat already fires
    push_beat(KIND_WAKE, 10'd1023, 1'b1);
    push_beat(KIND_TICK, 10'd1023, 1'b0);   // tick while asleep: ignored
    push_beat(KIND_WAKE, 10'd100,  1'b0);   // fires, sample equals threshold: skip
    push_beat(KIND_WAKE, 10'd0,    1'b1);
    push_beat(KIND_WAKE, 10'd101,  1'b0);
    push_beat(KIND_WAKE, 10'd101,  1'b1);   // fires, just above threshold: warm-up
    push_beat(KIND_WAKE, 10'd1023, 1'b0);   // wake while busy: ignored
    push_beat(KIND_TICK, 10'd0,    1'b0);
    push_beat(KIND_TICK, 10'd0,    1'b0);   // warm-up done, blanking starts
    push_beat(KIND_TICK, 10'd1023, 1'b0);   // ready ignored while blanked
    push_beat(KIND_TICK, 10'd0,    1'b0);
    repeat (4) push_beat(KIND_TICK, 10'd0, 1'b1);   // runs into the timeout
    push_beat(KIND_WAKE, 10'd1023, 1'b1);
    push_beat(KIND_WAKE, 10'd1023, 1'b1);
    push_beat(KIND_WAKE, 10'd1023, 1'b0);   // fires again
    repeat (2) push_beat(KIND_TICK, 10'd0, 1'b1);
    repeat (3) push_beat(KIND_TICK, 10'd0, 1'b0);   // ready taken once blanking ends
    repeat (2) push_beat(KIND_TICK, 10'd0, 1'b1);   // measure, then power-down
    // zero warm-up, blanking and measure time: steps skipped on the same beat
    load_setting(0, 100, 0, 0, 3, 0);
    push_beat(KIND_WAKE, 10'd1023, 1'b0);
    push_beat(KIND_WAKE, 10'd1023, 1'b0);
    push_beat(KIND_TICK, 10'd0,    1'b0);

    // ---- random settings, small times so attempts complete often ----
    for (int ph = 0; ph < 8; ph++) begin
      load_setting(($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(3),
                   $urandom_range(1023), $urandom_range(4), $urandom_range(5),
                   $urandom_range(6), $urandom_range(5));
      ready_low_pct = $urandom_range(10, 60);
      // one phase runs flat out on both sides
      src_idle_pct  = (ph == 2) ? 0 : 30;
      snk_idle_pct  = (ph == 2) ? 0 : 30;
      useful = 0;
      while (useful < 115) begin
        random_beat(ready_low_pct, counted);
        if (counted) useful++;
        // long hold-off on results while beats keep coming: input must stall
        if (ph == 3 && useful == 40 && counted) snk_hold = 80;
        // sender pause until everything is out, mid-setting
        if (ph == 5 && useful == 90 && counted) drain_results();
      end
    end
    src_idle_pct = 30;
    snk_idle_pct = 30;

    // ---- all registers at zero ----
    load_setting(0, 0, 0, 0, 0, 0);
    useful = 0;
    while (useful < 60) begin
      random_beat(50, counted);
      if (counted) useful++;
    end
    // with zero times any tick ends a pending attempt at once
    while (sb.phase != PH_SLEEP) push_beat(KIND_TICK, 10'd0, 1'b1);

    // ---- widest limit, threshold and blanking ----
    // limit 255 needs the count to reach 256; full-scale sample just above threshold
    load_setting(255, 1022, 2, 16383, 16383, 65535);
    wake_until_fired(10'd1023);
    repeat (30) push_beat(KIND_TICK, 10'd0, 1'b0);   // ready ignored deep in blanking

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
